### rtl/core/tile_map_rect_fill_defines.svh
// Assertion macros for the tile map rectangle fill block.
// Used by the modules that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef TILE_MAP_RECT_FILL_DEFINES_SVH
`define TILE_MAP_RECT_FILL_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TMRF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define TMRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/tmrf_pkg.sv
// Shared constants, codes and types of the tile map rectangle fill block.
// No dependencies; the interfaces, tmrf_cfg, tmrf_ctrl and the top refer to it by scoped names.
`default_nettype none

package tmrf_pkg;

    // Grid geometry and tile storage
    localparam int MAX_COLS  = 64;
    localparam int MAX_ROWS  = 64;
    localparam int TYPE_BITS = 4;
    localparam int COL_BITS  = $clog2(MAX_COLS);
    localparam int ROW_BITS  = $clog2(MAX_ROWS);
    localparam int ADDR_BITS = COL_BITS + ROW_BITS;
    localparam int DEPTH     = MAX_COLS * MAX_ROWS;

    // Field widths of the channels
    localparam int OP_BITS      = 2;
    localparam int COORD_BITS   = 6;
    localparam int STATUS_BITS  = 2;
    localparam int NB_BITS      = 4;
    localparam int DIM_BITS     = 7;
    localparam int CODE_BITS    = 4;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = DIM_BITS;

    // Operations
    typedef logic [OP_BITS-1:0] t_op;
    localparam t_op OP_FILL  = 2'd0;
    localparam t_op OP_MARK  = 2'd1;
    localparam t_op OP_QUERY = 2'd2;
    localparam t_op OP_CLEAR = 2'd3;

    // Result status
    typedef logic [STATUS_BITS-1:0] t_status;
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_BOUNDS = 2'd1;
    localparam t_status ST_ORDER  = 2'd2;

    // Configuration register indexes
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_COLS    = 2'd0;
    localparam t_cfg_idx CFG_ROWS    = 2'd1;
    localparam t_cfg_idx CFG_EMPTY   = 2'd2;
    localparam t_cfg_idx CFG_BLOCKED = 2'd3;

    // Register reset values
    localparam logic [DIM_BITS-1:0]  COLS_RESET    = DIM_BITS'(64);
    localparam logic [DIM_BITS-1:0]  ROWS_RESET    = DIM_BITS'(64);
    localparam logic [CODE_BITS-1:0] EMPTY_RESET   = CODE_BITS'(0);
    localparam logic [CODE_BITS-1:0] BLOCKED_RESET = CODE_BITS'(1);

    // Effective configuration seen by the controller
    typedef struct packed {
        logic [DIM_BITS-1:0]  cols;
        logic [DIM_BITS-1:0]  rows;
        logic [TYPE_BITS-1:0] empty_type;
        logic [CODE_BITS-1:0] blocked;
    } t_cfg;

    // Request to the type and mark memories (shared addresses)
    typedef struct packed {
        logic                 type_we;
        logic                 mark_we;
        logic [ADDR_BITS-1:0] waddr;
        logic [ADDR_BITS-1:0] raddr;
        logic [TYPE_BITS-1:0] type_wdata;
        logic                 mark_wdata;
    } t_mem_req;

    // Tile (x, y) sits at y * MAX_COLS + x
    function automatic logic [ADDR_BITS-1:0] tile_addr(
        input logic [COORD_BITS-1:0] x,
        input logic [COORD_BITS-1:0] y
    );
        return {y[ROW_BITS-1:0], x[COL_BITS-1:0]};
    endfunction

endpackage

`default_nettype wire

### rtl/core/tmrf_ifs.sv
// Channel interfaces of the tile map block: operation input, result output, register writes.
// Depends on tmrf_pkg for field widths.
`default_nettype none

interface tmrf_in_if;
    logic                                valid;
    logic                                ready;
    logic [tmrf_pkg::OP_BITS-1:0]        operation;
    logic [tmrf_pkg::COORD_BITS-1:0]     x_low;
    logic [tmrf_pkg::COORD_BITS-1:0]     y_low;
    logic [tmrf_pkg::COORD_BITS-1:0]     x_high;
    logic [tmrf_pkg::COORD_BITS-1:0]     y_high;
    logic [tmrf_pkg::TYPE_BITS-1:0]      tile_type;
    logic                                overwrite;
    logic                                mark_value;

    modport source (
        output valid, operation, x_low, y_low, x_high, y_high, tile_type, overwrite,
               mark_value,
        input  ready
    );
    modport sink (
        input  valid, operation, x_low, y_low, x_high, y_high, tile_type, overwrite,
               mark_value,
        output ready
    );
endinterface

interface tmrf_out_if;
    logic                                valid;
    logic                                ready;
    logic [tmrf_pkg::STATUS_BITS-1:0]    status;
    logic [tmrf_pkg::TYPE_BITS-1:0]      read_type;
    logic                                read_mark;
    logic [tmrf_pkg::NB_BITS-1:0]        open_neighbours;

    modport source (
        output valid, status, read_type, read_mark, open_neighbours,
        input  ready
    );
    modport sink (
        input  valid, status, read_type, read_mark, open_neighbours,
        output ready
    );
endinterface

interface tmrf_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [tmrf_pkg::CFG_IDX_BITS-1:0]    index;
    logic [tmrf_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/tmrf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; contents are undefined until written.
`default_nettype none

module tmrf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/tmrf_cfg.sv
// Configuration registers of the tile map block and their effective (clamped) values.
// Depends on tmrf_pkg and the tmrf_cfg_if interface.
`default_nettype none

module tmrf_cfg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    tmrf_cfg_if.sink            i_cfg,
    output      tmrf_pkg::t_cfg o_cfg
);

    logic [tmrf_pkg::DIM_BITS-1:0]  r_cols;
    logic [tmrf_pkg::DIM_BITS-1:0]  r_rows;
    logic [tmrf_pkg::CODE_BITS-1:0] r_empty;
    logic [tmrf_pkg::CODE_BITS-1:0] r_blocked;

    // Writes are taken in any cycle
    assign i_cfg.ready = 1'b1;

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols    <= tmrf_pkg::COLS_RESET;
            r_rows    <= tmrf_pkg::ROWS_RESET;
            r_empty   <= tmrf_pkg::EMPTY_RESET;
            r_blocked <= tmrf_pkg::BLOCKED_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                tmrf_pkg::CFG_COLS:    r_cols    <= i_cfg.data;
                tmrf_pkg::CFG_ROWS:    r_rows    <= i_cfg.data;
                tmrf_pkg::CFG_EMPTY:   r_empty   <= i_cfg.data[tmrf_pkg::CODE_BITS-1:0];
                tmrf_pkg::CFG_BLOCKED: r_blocked <= i_cfg.data[tmrf_pkg::CODE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Clamp grid size to 1..MAX, keep codes to the stored type width
    always_comb begin
        if (r_cols == '0) begin
            o_cfg.cols = tmrf_pkg::DIM_BITS'(1);
        end else if (r_cols > tmrf_pkg::DIM_BITS'(tmrf_pkg::MAX_COLS)) begin
            o_cfg.cols = tmrf_pkg::DIM_BITS'(tmrf_pkg::MAX_COLS);
        end else begin
            o_cfg.cols = r_cols;
        end
        if (r_rows == '0) begin
            o_cfg.rows = tmrf_pkg::DIM_BITS'(1);
        end else if (r_rows > tmrf_pkg::DIM_BITS'(tmrf_pkg::MAX_ROWS)) begin
            o_cfg.rows = tmrf_pkg::DIM_BITS'(tmrf_pkg::MAX_ROWS);
        end else begin
            o_cfg.rows = r_rows;
        end
        o_cfg.empty_type = r_empty[tmrf_pkg::TYPE_BITS-1:0];
        o_cfg.blocked    = r_blocked;
    end

endmodule

`default_nettype wire

### rtl/core/tmrf_ctrl.sv
// Sequencer of the tile map block: bounds checks, rectangle scan with read-modify-write,
// neighbour query, clearing sweep and the result register. Depends on tmrf_pkg, tmrf_ifs.
`default_nettype none
`include "tile_map_rect_fill_defines.svh"

module tmrf_ctrl (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    tmrf_in_if.sink                                 i_in,
    tmrf_out_if.source                              o_out,
    input  wire tmrf_pkg::t_cfg                     i_cfg,
    output      tmrf_pkg::t_mem_req                 o_mem,
    input  wire logic [tmrf_pkg::TYPE_BITS-1:0]     i_type_rdata,
    input  wire logic                               i_mark_rdata
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_QUERY = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Query read order
    localparam logic [2:0] Q_CENTER = 3'd0;
    localparam logic [2:0] Q_UP     = 3'd1;
    localparam logic [2:0] Q_DOWN   = 3'd2;
    localparam logic [2:0] Q_LEFT   = 3'd3;
    localparam logic [2:0] Q_RIGHT  = 3'd4;

    localparam int CB = tmrf_pkg::COORD_BITS;
    localparam int DB = tmrf_pkg::DIM_BITS;
    localparam int AB = tmrf_pkg::ADDR_BITS;

    logic [2:0]                       r_state, n_state;
    logic                             r_init;
    logic                             r_wv;
    logic [AB-1:0]                    r_cnt;
    logic                             r_out_valid;

    tmrf_pkg::t_op                    r_op;
    logic [CB-1:0]                    r_xl, r_yl, r_xh, r_yh, r_x, r_y;
    logic [tmrf_pkg::TYPE_BITS-1:0]   r_ttype;
    logic                             r_over;
    logic                             r_mval;
    logic [tmrf_pkg::TYPE_BITS-1:0]   r_clr_type;
    logic [2:0]                       r_qstep, r_wstep;
    logic [AB-1:0]                    r_waddr;

    tmrf_pkg::t_status                r_status;
    logic [tmrf_pkg::TYPE_BITS-1:0]   r_rtype;
    logic                             r_rmark;
    logic [tmrf_pkg::NB_BITS-1:0]     r_open;

    tmrf_pkg::t_status                r_out_status;
    logic [tmrf_pkg::TYPE_BITS-1:0]   r_out_rtype;
    logic                             r_out_rmark;
    logic [tmrf_pkg::NB_BITS-1:0]     r_out_open;

    logic                             in_acc;
    logic                             out_load;
    tmrf_pkg::t_status                acc_status;
    logic                             xl_out, yl_out, xh_out, yh_out;
    logic                             scan_last_x, scan_last;
    logic [AB-1:0]                    q_addr;
    logic                             up_ok, down_ok, left_ok, right_ok;
    logic                             nb_open;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // Check corners of the incoming transaction
    always_comb begin
        xl_out = DB'(i_in.x_low)  >= i_cfg.cols;
        yl_out = DB'(i_in.y_low)  >= i_cfg.rows;
        xh_out = DB'(i_in.x_high) >= i_cfg.cols;
        yh_out = DB'(i_in.y_high) >= i_cfg.rows;
        acc_status = tmrf_pkg::ST_OK;
        case (i_in.operation)
            tmrf_pkg::OP_QUERY: begin
                if (xl_out || yl_out) begin
                    acc_status = tmrf_pkg::ST_BOUNDS;
                end
            end
            tmrf_pkg::OP_CLEAR: acc_status = tmrf_pkg::ST_OK;
            default: begin
                if (xl_out || yl_out || xh_out || yh_out) begin
                    acc_status = tmrf_pkg::ST_BOUNDS;
                end else if (i_in.x_low > i_in.x_high || i_in.y_low > i_in.y_high) begin
                    acc_status = tmrf_pkg::ST_ORDER;
                end
            end
        endcase
    end

    // Scan position and query addresses
    assign scan_last_x = (r_x == r_xh);
    assign scan_last   = scan_last_x && (r_y == r_yh);

    always_comb begin
        case (r_qstep)
            Q_CENTER: q_addr = tmrf_pkg::tile_addr(r_xl, r_yl);
            Q_UP:     q_addr = tmrf_pkg::tile_addr(r_xl, r_yl + CB'(1));
            Q_DOWN:   q_addr = tmrf_pkg::tile_addr(r_xl, r_yl - CB'(1));
            Q_LEFT:   q_addr = tmrf_pkg::tile_addr(r_xl - CB'(1), r_yl);
            Q_RIGHT:  q_addr = tmrf_pkg::tile_addr(r_xl + CB'(1), r_yl);
            default:  q_addr = tmrf_pkg::tile_addr(r_xl, r_yl);
        endcase
    end

    // Neighbour presence inside the grid in use
    assign up_ok    = (DB'(r_yl) + DB'(1)) < i_cfg.rows;
    assign down_ok  = (r_yl != '0);
    assign left_ok  = (r_xl != '0);
    assign right_ok = (DB'(r_xl) + DB'(1)) < i_cfg.cols;
    assign nb_open  = (tmrf_pkg::CODE_BITS'(i_type_rdata) != i_cfg.blocked);

    // Memory requests: clearing sweep, or write-back in the cycle after the scan read
    always_comb begin
        o_mem            = '0;
        o_mem.type_wdata = r_ttype;
        o_mem.mark_wdata = r_mval;
        o_mem.waddr      = r_waddr;
        case (r_state)
            S_SCAN:  o_mem.raddr = tmrf_pkg::tile_addr(r_x, r_y);
            S_QUERY: o_mem.raddr = q_addr;
            default: o_mem.raddr = tmrf_pkg::tile_addr(r_x, r_y);
        endcase
        if (r_state == S_CLEAR) begin
            o_mem.type_we    = 1'b1;
            o_mem.mark_we    = 1'b1;
            o_mem.waddr      = r_cnt;
            o_mem.type_wdata = r_clr_type;
            o_mem.mark_wdata = 1'b0;
        end else if (r_wv && r_op == tmrf_pkg::OP_FILL) begin
            o_mem.type_we = r_over || (i_type_rdata == i_cfg.empty_type);
        end else if (r_wv && r_op == tmrf_pkg::OP_MARK) begin
            o_mem.mark_we = 1'b1;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.operation == tmrf_pkg::OP_CLEAR) begin
                        n_state = S_CLEAR;
                    end else if (acc_status != tmrf_pkg::ST_OK) begin
                        n_state = S_DONE;
                    end else if (i_in.operation == tmrf_pkg::OP_QUERY) begin
                        n_state = S_QUERY;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_CLEAR: begin
                if (r_cnt == AB'(tmrf_pkg::DEPTH - 1)) begin
                    n_state = r_init ? S_IDLE : S_DONE;
                end
            end
            S_SCAN:  if (scan_last) n_state = S_DRAIN;
            S_QUERY: if (r_qstep == Q_RIGHT) n_state = S_DRAIN;
            S_DRAIN: n_state = S_DONE;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_init      <= 1'b1;
            r_cnt       <= '0;
            r_clr_type  <= '0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wv    <= (r_state == S_SCAN) || (r_state == S_QUERY);
            if (r_state == S_CLEAR) begin
                r_cnt <= r_cnt + AB'(1);
                if (r_cnt == AB'(tmrf_pkg::DEPTH - 1)) begin
                    r_init <= 1'b0;
                end
            end
            if (in_acc) begin
                r_cnt      <= '0;
                r_clr_type <= i_cfg.empty_type;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Transaction fields, scan position and result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= i_in.operation;
            r_xl     <= i_in.x_low;
            r_yl     <= i_in.y_low;
            r_xh     <= i_in.x_high;
            r_yh     <= i_in.y_high;
            r_ttype  <= i_in.tile_type;
            r_over   <= i_in.overwrite;
            r_mval   <= i_in.mark_value;
            r_x      <= i_in.x_low;
            r_y      <= i_in.y_low;
            r_qstep  <= Q_CENTER;
            r_status <= acc_status;
            r_rtype  <= '0;
            r_rmark  <= 1'b0;
            r_open   <= '0;
        end
        // Advance the scan one tile a cycle, row by row
        if (r_state == S_SCAN) begin
            r_waddr <= tmrf_pkg::tile_addr(r_x, r_y);
            if (scan_last_x) begin
                r_x <= r_xl;
                r_y <= r_y + CB'(1);
            end else begin
                r_x <= r_x + CB'(1);
            end
        end
        // Step through the five query reads
        if (r_state == S_QUERY) begin
            r_wstep <= r_qstep;
            r_qstep <= r_qstep + 3'd1;
        end
        // Capture query read data
        if (r_wv && r_op == tmrf_pkg::OP_QUERY) begin
            case (r_wstep)
                Q_CENTER: begin
                    r_rtype <= i_type_rdata;
                    r_rmark <= i_mark_rdata;
                end
                Q_UP:    r_open[0] <= up_ok && nb_open;
                Q_DOWN:  r_open[1] <= down_ok && nb_open;
                Q_LEFT:  r_open[2] <= left_ok && nb_open;
                Q_RIGHT: r_open[3] <= right_ok && nb_open;
                default: ;
            endcase
        end
        if (out_load) begin
            r_out_status <= r_status;
            r_out_rtype  <= r_rtype;
            r_out_rmark  <= r_rmark;
            r_out_open   <= r_open;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out_status;
    assign o_out.read_type       = r_out_rtype;
    assign o_out.read_mark       = r_out_rmark;
    assign o_out.open_neighbours = r_out_open;

    // Checks
    `TMRF_ASSERT_IMP(a_scan_in_rect, r_state == S_SCAN,
        r_x >= r_xl && r_x <= r_xh && r_y >= r_yl && r_y <= r_yh,
        "scan position left the rectangle")
    `TMRF_ASSERT_IMP(a_type_write_fill_only, o_mem.type_we && r_state != S_CLEAR,
        r_op == tmrf_pkg::OP_FILL, "type write outside fill or clear")
    `TMRF_ASSERT_IMP(a_fail_fields_zero, r_state == S_DONE && r_status != tmrf_pkg::ST_OK,
        r_rtype == '0 && r_rmark == 1'b0 && r_open == '0, "failed result carries data")
    `TMRF_ASSERT_IMP(a_no_accept_in_init, i_in.valid && i_in.ready, !r_init,
        "transaction taken during clearing pass")
    `TMRF_ASSERT_NEXT(a_clear_starts, i_in.valid && i_in.ready &&
        i_in.operation == tmrf_pkg::OP_CLEAR, r_state == S_CLEAR && r_cnt == '0,
        "clear did not start its sweep")

endmodule

`default_nettype wire

### rtl/core/tile_map_rect_fill.sv
// Tile map rectangle fill: a 64 x 64 tile store (type code and mark bit) in two RAMs.
// Fill/mark walks the W x H rectangle one tile per cycle through the RAM read-modify-write;
// a query makes five reads, clear sweeps the whole store, a failed check goes straight to the result.
// Throughput: one transaction at a time; the next is taken while the result waits in its register.
// Reset: registers take their defaults, then a pass over every tile zeroes the store, input not ready.
`default_nettype none

module tile_map_rect_fill (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tmrf_in_if.sink     i_in,
    tmrf_out_if.source  o_out,
    tmrf_cfg_if.sink    i_cfg
);

    tmrf_pkg::t_cfg                    cfg;
    tmrf_pkg::t_mem_req                mem;
    logic [tmrf_pkg::TYPE_BITS-1:0]    type_rdata;
    logic                              mark_rdata;

    // Configuration registers
    tmrf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Tile type store
    tmrf_ram #(
        .WIDTH (tmrf_pkg::TYPE_BITS),
        .DEPTH (tmrf_pkg::DEPTH)
    ) u_type_ram (
        .i_clk   (i_clk),
        .i_we    (mem.type_we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.type_wdata),
        .i_raddr (mem.raddr),
        .o_rdata (type_rdata)
    );

    // Tile mark store
    tmrf_ram #(
        .WIDTH (1),
        .DEPTH (tmrf_pkg::DEPTH)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mem.mark_we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.mark_wdata),
        .i_raddr (mem.raddr),
        .o_rdata (mark_rdata)
    );

    // Sequencer and result register
    tmrf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_out        (o_out),
        .i_cfg        (cfg),
        .o_mem        (mem),
        .i_type_rdata (type_rdata),
        .i_mark_rdata (mark_rdata)
    );

endmodule

`default_nettype wire

### verif/tile_map_rect_fill_tb.sv
`timescale 1ns / 100ps
// Testbench for tile_map_rect_fill: directed and random fill, mark, query and clear transactions
// checked against an in-bench model of the tile store. Needs tmrf_pkg, tmrf_ifs.sv and the block.

module tile_map_rect_fill_tb;
    import tmrf_pkg::*;

    // Neighbour bit positions in open_neighbours
    localparam int NB_UP    = 0;
    localparam int NB_DOWN  = 1;
    localparam int NB_LEFT  = 2;
    localparam int NB_RIGHT = 3;

    typedef struct packed {
        t_op                   op;
        logic [COORD_BITS-1:0] x_lo;
        logic [COORD_BITS-1:0] y_lo;
        logic [COORD_BITS-1:0] x_hi;
        logic [COORD_BITS-1:0] y_hi;
        logic [TYPE_BITS-1:0]  ttype;
        logic                  overwrite;
        logic                  mark_value;
    } tile_op_t;

    typedef struct packed {
        t_status              status;
        logic [TYPE_BITS-1:0] read_type;
        logic                 read_mark;
        logic [NB_BITS-1:0]   open_nb;
    } tile_result_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tmrf_in_if  in_bus ();
    tmrf_out_if out_bus ();
    tmrf_cfg_if cfg_bus ();

    tile_map_rect_fill u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    // Bench-side drive registers
    logic                     in_valid  = 1'b0;
    tile_op_t                 in_op     = '0;
    logic                     out_ready = 1'b0;
    logic                     cfg_valid = 1'b0;
    t_cfg_idx                 cfg_index = CFG_COLS;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    assign in_bus.valid      = in_valid;
    assign in_bus.operation  = in_op.op;
    assign in_bus.x_low      = in_op.x_lo;
    assign in_bus.y_low      = in_op.y_lo;
    assign in_bus.x_high     = in_op.x_hi;
    assign in_bus.y_high     = in_op.y_hi;
    assign in_bus.tile_type  = in_op.ttype;
    assign in_bus.overwrite  = in_op.overwrite;
    assign in_bus.mark_value = in_op.mark_value;
    assign out_bus.ready     = out_ready;
    assign cfg_bus.valid     = cfg_valid;
    assign cfg_bus.index     = cfg_index;
    assign cfg_bus.data      = cfg_data;

    // Model of the tile store and its registers
    logic [TYPE_BITS-1:0] model_type [DEPTH];
    logic                 model_mark [DEPTH];
    logic [DIM_BITS-1:0]  model_cols    = COLS_RESET;
    logic [DIM_BITS-1:0]  model_rows    = ROWS_RESET;
    logic [TYPE_BITS-1:0] model_empty   = EMPTY_RESET;
    logic [CODE_BITS-1:0] model_blocked = BLOCKED_RESET;

    tile_op_t     tile_ops_to_send[$];
    tile_result_t pending_tile_results[$];

    int unsigned in_gap = 0, in_calm = 0, out_stall = 0, out_calm = 0;
    int unsigned fail_count = 0, results_checked = 0, settings_used = 1;
    int unsigned rejected_bounds = 0, rejected_order = 0;
    int unsigned ops_accepted [4] = '{0, 0, 0, 0};

    initial forever #1 i_clk = ~i_clk;

    // Register value 0 counts as 1, anything past the maximum as the maximum
    function automatic int unsigned used_dim(logic [DIM_BITS-1:0] reg_val, int unsigned max_dim);
        if (reg_val == 0) return 1;
        if (reg_val > max_dim) return max_dim;
        return reg_val;
    endfunction

    function automatic int unsigned tile_index(int unsigned x, int unsigned y);
        return (y * MAX_COLS + x) % DEPTH;
    endfunction

    // Apply one operation to the model store and return the result it yields
    function automatic tile_result_t apply_tile_op(tile_op_t t);
        tile_result_t res;
        int unsigned  cols, rows, xl, yl, xh, yh, a;
        res  = '0;
        cols = used_dim(model_cols, MAX_COLS);
        rows = used_dim(model_rows, MAX_ROWS);
        xl   = t.x_lo;
        yl   = t.y_lo;
        xh   = t.x_hi;
        yh   = t.y_hi;
        if (t.op == OP_CLEAR) begin
            for (int i = 0; i < DEPTH; i++) begin
                model_type[i] = model_empty;
                model_mark[i] = 1'b0;
            end
        end else if (t.op == OP_QUERY) begin
            if (xl >= cols || yl >= rows) begin
                res.status = ST_BOUNDS;
            end else begin
                a = tile_index(xl, yl);
                res.read_type = model_type[a];
                res.read_mark = model_mark[a];
                res.open_nb[NB_UP]    = (yl + 1 < rows) &&
                                        model_type[tile_index(xl, yl + 1)] != model_blocked;
                res.open_nb[NB_DOWN]  = (yl > 0) &&
                                        model_type[tile_index(xl, yl - 1)] != model_blocked;
                res.open_nb[NB_LEFT]  = (xl > 0) &&
                                        model_type[tile_index(xl - 1, yl)] != model_blocked;
                res.open_nb[NB_RIGHT] = (xl + 1 < cols) &&
                                        model_type[tile_index(xl + 1, yl)] != model_blocked;
            end
        end else if (xl >= cols || xh >= cols || yl >= rows || yh >= rows) begin
            res.status = ST_BOUNDS;
        end else if (xl > xh || yl > yh) begin
            res.status = ST_ORDER;
        end else begin
            // Walk the inclusive rectangle
            for (int unsigned y = yl; y <= yh; y++) begin
                for (int unsigned x = xl; x <= xh; x++) begin
                    a = tile_index(x, y);
                    if (t.op == OP_FILL) begin
                        if (t.overwrite || model_type[a] == model_empty)
                            model_type[a] = t.ttype;
                    end else begin
                        model_mark[a] = t.mark_value;
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic tile_op_t make_op(t_op op, int unsigned xl, int unsigned yl,
                                         int unsigned xh, int unsigned yh,
                                         int unsigned ttype = 0, int unsigned over = 0,
                                         int unsigned mval = 0);
        tile_op_t t;
        t.op         = op;
        t.x_lo       = COORD_BITS'(xl);
        t.y_lo       = COORD_BITS'(yl);
        t.x_hi       = COORD_BITS'(xh);
        t.y_hi       = COORD_BITS'(yh);
        t.ttype      = TYPE_BITS'(ttype);
        t.overwrite  = 1'(over);
        t.mark_value = 1'(mval);
        return t;
    endfunction

    // Mostly short idles, a few long ones
    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Rectangle side: mostly tiny, some medium, rarely the whole grid
    function automatic int unsigned pick_span(int unsigned limit);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return limit;
        if (r < 25) return $urandom_range(1, (limit < 16) ? limit : 16);
        return $urandom_range(1, (limit < 4) ? limit : 4);
    endfunction

    // Well-formed rectangles and in-grid queries, with some noise and swapped corners
    function automatic tile_op_t random_tile_op();
        tile_op_t              t;
        int unsigned           cols, rows, w, h, pick;
        logic [COORD_BITS-1:0] tmp;
        cols = used_dim(model_cols, MAX_COLS);
        rows = used_dim(model_rows, MAX_ROWS);
        t    = '0;
        pick = $urandom_range(0, 99);
        if (pick < 4) t.op = OP_CLEAR;
        else if (pick < 40) t.op = OP_FILL;
        else if (pick < 60) t.op = OP_MARK;
        else t.op = OP_QUERY;
        w = pick_span(cols);
        h = pick_span(rows);
        t.x_lo = COORD_BITS'($urandom_range(0, cols - w));
        t.y_lo = COORD_BITS'($urandom_range(0, rows - h));
        t.x_hi = COORD_BITS'(t.x_lo + w - 1);
        t.y_hi = COORD_BITS'(t.y_lo + h - 1);
        if (t.op == OP_QUERY) begin
            t.x_lo = COORD_BITS'($urandom_range(0, cols - 1));
            t.y_lo = COORD_BITS'($urandom_range(0, rows - 1));
            t.x_hi = COORD_BITS'($urandom);
            t.y_hi = COORD_BITS'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            t.x_lo = COORD_BITS'($urandom);
            t.y_lo = COORD_BITS'($urandom);
            t.x_hi = COORD_BITS'($urandom);
            t.y_hi = COORD_BITS'($urandom);
        end else if (pick < 18) begin
            if (t.x_lo != t.x_hi) begin
                tmp = t.x_lo; t.x_lo = t.x_hi; t.x_hi = tmp;
            end else begin
                tmp = t.y_lo; t.y_lo = t.y_hi; t.y_hi = tmp;
            end
        end
        // Lean on blocked and empty codes so queries and non-overwrite fills see them
        pick = $urandom_range(0, 9);
        if (pick < 3) t.ttype = model_blocked;
        else if (pick < 5) t.ttype = model_empty;
        else t.ttype = TYPE_BITS'($urandom);
        t.overwrite  = 1'($urandom);
        t.mark_value = 1'($urandom);
        return t;
    endfunction

    task automatic queue_random(int unsigned count);
        repeat (count) tile_ops_to_send.push_back(random_tile_op());
    endtask

    // Sample at the falling edge so the drive registers have settled
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (tile_ops_to_send.size() != 0 || in_valid || pending_tile_results.size() != 0);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg_bus.ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_COLS:    model_cols    = value;
            CFG_ROWS:    model_rows    = value;
            CFG_EMPTY:   model_empty   = value[TYPE_BITS-1:0];
            CFG_BLOCKED: model_blocked = value[CODE_BITS-1:0];
            default: ;
        endcase
    endtask

    // Reprogram all registers once the block has gone quiet; code registers get junk upper bits
    task automatic set_grid(int unsigned cols, int unsigned rows, int unsigned empty,
                            int unsigned blocked);
        wait_drained();
        repeat (8) @(posedge i_clk);
        write_reg(CFG_COLS, CFG_DATA_BITS'(cols));
        write_reg(CFG_ROWS, CFG_DATA_BITS'(rows));
        write_reg(CFG_EMPTY, CFG_DATA_BITS'(($urandom_range(0, 7) << CODE_BITS) | empty));
        write_reg(CFG_BLOCKED, CFG_DATA_BITS'(($urandom_range(0, 7) << CODE_BITS) | blocked));
        settings_used++;
    endtask

    task automatic compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    task automatic check_tile_result();
        tile_result_t want;
        if (pending_tile_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual status %0d type %0d",
                     $time, out_bus.status, out_bus.read_type);
            fail_count++;
        end else begin
            want = pending_tile_results.pop_front();
            results_checked++;
            if (want.status == ST_BOUNDS) rejected_bounds++;
            if (want.status == ST_ORDER) rejected_order++;
            compare_field("status", want.status, out_bus.status);
            compare_field("read_type", want.read_type, out_bus.read_type);
            compare_field("read_mark", want.read_mark, out_bus.read_mark);
            compare_field("open_neighbours", want.open_nb, out_bus.open_neighbours);
        end
    endtask

    // Driver: predict on acceptance, then idle or present the next pending operation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_calm > 0) in_calm--;
            else if ($urandom_range(0, 199) == 0) in_calm = $urandom_range(20, 200);
            if (in_valid && in_bus.ready) begin
                pending_tile_results.push_back(apply_tile_op(in_op));
                ops_accepted[in_op.op]++;
                in_gap = (in_calm > 0) ? 0 : pick_idle();
            end
            if (in_valid && !in_bus.ready) begin
                in_valid <= 1'b1;
            end else if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (tile_ops_to_send.size() != 0) begin
                in_op    <= tile_ops_to_send.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transaction, stall the result channel at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (out_calm > 0) out_calm--;
            else if ($urandom_range(0, 199) == 0) out_calm = $urandom_range(20, 200);
            if (out_bus.valid && out_ready) check_tile_result();
            if (out_stall > 0) begin
                out_stall--;
                out_ready <= (out_stall == 0);
            end else if (out_calm == 0 &&
                         ((out_bus.valid && out_ready) || $urandom_range(0, 15) == 0)) begin
                out_stall = pick_idle();
                out_ready <= (out_stall == 0);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        for (int i = 0; i < DEPTH; i++) begin
            model_type[i] = '0;
            model_mark[i] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default 64 x 64 grid, empty 0, blocked 1
        tile_ops_to_send.push_back(make_op(OP_QUERY, 0, 0, 63, 63));
        tile_ops_to_send.push_back(make_op(OP_FILL, 0, 0, 63, 63, 2, 0));
        tile_ops_to_send.push_back(make_op(OP_FILL, 10, 10, 12, 12, 1, 1));
        tile_ops_to_send.push_back(make_op(OP_FILL, 11, 11, 11, 11, 5, 0));
        tile_ops_to_send.push_back(make_op(OP_QUERY, 11, 11, 0, 0));
        tile_ops_to_send.push_back(make_op(OP_QUERY, 13, 11, 0, 0));
        tile_ops_to_send.push_back(make_op(OP_MARK, 60, 60, 63, 63, 0, 0, 1));
        tile_ops_to_send.push_back(make_op(OP_QUERY, 63, 63, 63, 63));
        tile_ops_to_send.push_back(make_op(OP_MARK, 62, 62, 62, 62, 15, 1, 0));
        tile_ops_to_send.push_back(make_op(OP_QUERY, 62, 62, 1, 1));
        // Corners out of order
        tile_ops_to_send.push_back(make_op(OP_FILL, 20, 0, 19, 5, 3, 1));
        tile_ops_to_send.push_back(make_op(OP_MARK, 0, 5, 3, 4, 0, 0, 1));
        tile_ops_to_send.push_back(make_op(OP_CLEAR, 63, 63, 0, 0, 15, 1, 1));
        tile_ops_to_send.push_back(make_op(OP_QUERY, 11, 11, 0, 0));
        tile_ops_to_send.push_back(make_op(OP_FILL, 0, 0, 0, 0, 15, 1));
        tile_ops_to_send.push_back(make_op(OP_FILL, 0, 0, 1, 0, 9, 0));
        tile_ops_to_send.push_back(make_op(OP_QUERY, 0, 1, 0, 0));
        tile_ops_to_send.push_back(make_op(OP_QUERY, 1, 0, 0, 0));
        // Marking a row segment leaves the row above alone
        tile_ops_to_send.push_back(make_op(OP_MARK, 0, 0, 63, 0, 0, 0, 1));
        tile_ops_to_send.push_back(make_op(OP_QUERY, 5, 1, 0, 0));
        tile_ops_to_send.push_back(make_op(OP_QUERY, 5, 0, 0, 0));

        // Small grid: bounds checks, bounds taking priority over order
        set_grid(5, 3, 0, 1);
        tile_ops_to_send.push_back(make_op(OP_FILL, 0, 0, 5, 0, 4, 1));
        tile_ops_to_send.push_back(make_op(OP_QUERY, 4, 3, 0, 0));
        tile_ops_to_send.push_back(make_op(OP_MARK, 40, 2, 3, 1, 0, 0, 1));
        queue_random(20);

        // Column register 0 acts as a single column
        set_grid(0, 1, 15, 0);
        tile_ops_to_send.push_back(make_op(OP_CLEAR, 0, 0, 0, 0));
        queue_random(10);

        // Oversized registers clamp to the full grid
        set_grid(127, 100, 7, 15);
        queue_random(30);

        // Blocked code equal to the empty code
        set_grid(12, 40, 3, 3);
        queue_random(25);

        set_grid(64, 64, 0, 1);
        queue_random(30);

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d grid settings: %0d fill, %0d mark, %0d query, %0d clear transactions",
                 settings_used, ops_accepted[OP_FILL], ops_accepted[OP_MARK],
                 ops_accepted[OP_QUERY], ops_accepted[OP_CLEAR]);
        $display("%0d results checked (%0d out of bounds, %0d out of order), %0d mismatches",
                 results_checked, rejected_bounds, rejected_order, fail_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("%0t: run timed out with %0d results outstanding",
                 $time, pending_tile_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/tmrf_pkg.sv
rtl/core/tmrf_ifs.sv
rtl/core/tmrf_ram.sv
rtl/core/tmrf_cfg.sv
rtl/core/tmrf_ctrl.sv
rtl/core/tile_map_rect_fill.sv
verif/tile_map_rect_fill_tb.sv
